/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising edge of aclk outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Checks that a condition on one edge implies another on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/scss_pkg.sv */
package scss_pkg;

    localparam int RING_DEPTH = 4;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    typedef logic [RING_AW-1:0] ring_idx_t;

    typedef enum logic [2:0] {
        FUNC_STEP       = 3'd0,
        FUNC_WRITE_CONF = 3'd1,
        FUNC_START      = 3'd2,
        FUNC_STOP       = 3'd3,
        FUNC_POP        = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_WRITE     = 2'd1,
        CMD_READ_FULL = 2'd2,
        CMD_READ_ADC  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_READY_TIMEOUT = 3'd0,
        CFG_APPLY_DELAY   = 3'd1,
        CFG_SAMPLE_DELAY  = 3'd2,
        CFG_READ_RETRY    = 3'd3,
        CFG_CHECK_RETRY   = 3'd4
    } cfg_idx_t;

    localparam logic [15:0] RESET_READY_TIMEOUT = 16'd6;
    localparam logic [15:0] RESET_APPLY_DELAY   = 16'd3;
    localparam logic [15:0] RESET_SAMPLE_DELAY  = 16'd75;
    localparam logic [7:0]  RESET_READ_RETRY    = 8'd2;
    localparam logic [7:0]  RESET_CHECK_RETRY   = 8'd2;

    typedef enum logic [2:0] {
        TM_IDLE   = 3'b001,
        TM_CONF   = 3'b010,
        TM_SAMPLE = 3'b100
    } top_mode_t;

    typedef enum logic [8:0] {
        CP_INIT       = 9'b000000001,
        CP_WAIT_WRITE = 9'b000000010,
        CP_WRITE      = 9'b000000100,
        CP_WAIT_APPLY = 9'b000001000,
        CP_WAIT_READ  = 9'b000010000,
        CP_READ       = 9'b000100000,
        CP_WAIT_CHECK = 9'b001000000,
        CP_CHECK      = 9'b010000000,
        CP_READY      = 9'b100000000
    } conf_phase_t;

    typedef enum logic [4:0] {
        SP_INIT       = 5'b00001,
        SP_WAIT_READY = 5'b00010,
        SP_REQUEST    = 5'b00100,
        SP_WAIT_DATA  = 5'b01000,
        SP_DELAY      = 5'b10000
    } samp_phase_t;

    typedef struct packed {
        logic [15:0] ready_timeout;
        logic [15:0] apply_delay;
        logic [15:0] sample_delay;
        logic [7:0]  read_retry_limit;
        logic [7:0]  check_retry_limit;
    } cfg_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] now;
        logic        sensor_ready;
        logic        rx_ok;
        logic [24:0] rx_conf_word;
        logic [13:0] rx_adc_value;
        logic        rx_out_of_range;
        logic [24:0] new_conf_word;
    } item_t;

    typedef struct packed {
        logic        write_pending;
        logic        ready;
        logic        verified;
        cmd_t        cmd;
        logic [24:0] write_word;
    } conf_stat_t;

    typedef struct packed {
        logic        sampling_on;
        cmd_t        cmd;
        logic        pop_valid;
        logic [13:0] pop_value;
        logic [31:0] pop_time;
    } samp_stat_t;

    typedef struct packed {
        cmd_t        link_cmd;
        logic [24:0] write_word;
        logic        sample_valid;
        logic [13:0] sample_value;
        logic [31:0] sample_time;
        logic        conf_verified;
    } result_t;

    typedef struct packed {
        logic [13:0] value;
        logic [31:0] stamp;
    } ring_entry_t;

    // The backward distance carries an extra tick; it is kept as the sensor
    // firmware defines it.
    function automatic logic elapsed(logic [31:0] now, logic [31:0] start,
                                     logic [15:0] limit);
        logic [31:0] fwd;
        logic [31:0] back;
        fwd  = now - start;
        back = start - now + 32'd1;
        return ((now >= start) ? fwd : back) > {16'd0, limit};
    endfunction

    function automatic logic [7:0] sat_inc(logic [7:0] v);
        return (v != 8'hFF) ? v + 8'd1 : v;
    endfunction

    function automatic ring_idx_t ring_next(ring_idx_t i);
        return (i == RING_AW'(RING_DEPTH - 1)) ? '0 : i + RING_AW'(1);
    endfunction

endpackage

/* sv/scss_conf_fsm.sv */
module scss_conf_fsm (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  scss_pkg::cfg_t          cfg,
    input  scss_pkg::item_t         item,
    input  logic                    take_write,
    input  logic                    run,
    output scss_pkg::conf_stat_t    stat
);

    scss_pkg::conf_phase_t phase_reg, phase_next, phase_eff, step_phase;
    logic [31:0] start_reg, start_next, start_eff, step_start;
    logic [7:0]  rrc_reg, rrc_next, step_rrc;
    logic [7:0]  chk_reg, chk_next, step_chk;
    logic        ver_reg, ver_next, step_ver;
    logic        wp_reg, wp_next;
    logic [24:0] pw_reg, pw_next;
    logic [15:0] limit;
    logic        timed_out;
    scss_pkg::cmd_t step_cmd;

    always_comb begin
        // A pending write restarts the sequence within this same step.
        phase_eff = wp_reg ? scss_pkg::CP_WAIT_WRITE : phase_reg;
        start_eff = wp_reg ? item.now : start_reg;
        limit     = (phase_eff == scss_pkg::CP_WAIT_APPLY) ? cfg.apply_delay
                                                           : cfg.ready_timeout;
        timed_out = scss_pkg::elapsed(item.now, start_eff, limit);

        step_phase = phase_eff;
        step_start = start_eff;
        step_rrc   = rrc_reg;
        step_chk   = chk_reg;
        step_ver   = ver_reg;
        step_cmd   = scss_pkg::CMD_NONE;

        unique case (phase_eff)
            scss_pkg::CP_INIT, scss_pkg::CP_READY: begin
            end
            scss_pkg::CP_WAIT_WRITE: begin
                if (item.sensor_ready || timed_out) begin
                    step_phase = scss_pkg::CP_WRITE;
                end
            end
            scss_pkg::CP_WRITE: begin
                step_cmd   = scss_pkg::CMD_WRITE;
                step_chk   = 8'd0;
                step_start = item.now;
                step_phase = scss_pkg::CP_WAIT_APPLY;
            end
            scss_pkg::CP_WAIT_APPLY: begin
                if (timed_out) begin
                    step_start = item.now;
                    step_rrc   = 8'd0;
                    step_phase = scss_pkg::CP_WAIT_READ;
                end
            end
            scss_pkg::CP_WAIT_READ: begin
                if (item.sensor_ready || timed_out) begin
                    step_phase = scss_pkg::CP_READ;
                end
            end
            scss_pkg::CP_READ: begin
                step_cmd   = scss_pkg::CMD_READ_FULL;
                step_start = item.now;
                step_phase = scss_pkg::CP_WAIT_CHECK;
            end
            scss_pkg::CP_WAIT_CHECK: begin
                if (item.sensor_ready) begin
                    step_phase = scss_pkg::CP_CHECK;
                end else if (timed_out) begin
                    step_phase = (rrc_reg < cfg.read_retry_limit) ? scss_pkg::CP_READ
                                                                  : scss_pkg::CP_WRITE;
                    step_rrc   = scss_pkg::sat_inc(rrc_reg);
                end
            end
            scss_pkg::CP_CHECK: begin
                // The readback is compared whatever the frame status says.
                if (item.rx_conf_word == pw_reg) begin
                    step_ver   = 1'b1;
                    step_phase = scss_pkg::CP_READY;
                end else begin
                    step_phase = (chk_reg < cfg.check_retry_limit) ? scss_pkg::CP_READ
                                                                   : scss_pkg::CP_WRITE;
                    step_chk   = scss_pkg::sat_inc(chk_reg);
                end
            end
            default: begin
            end
        endcase

        phase_next = run ? step_phase : phase_reg;
        start_next = run ? step_start : start_reg;
        rrc_next   = run ? step_rrc   : rrc_reg;
        chk_next   = run ? step_chk   : chk_reg;
        ver_next   = run ? step_ver   : ver_reg;
        wp_next    = take_write ? 1'b1 : (run ? 1'b0 : wp_reg);
        pw_next    = take_write ? item.new_conf_word : pw_reg;

        stat.write_pending = wp_reg;
        stat.ready         = (phase_reg == scss_pkg::CP_READY);
        stat.verified      = ver_next;
        stat.cmd           = run ? step_cmd : scss_pkg::CMD_NONE;
        stat.write_word    = (stat.cmd == scss_pkg::CMD_WRITE) ? pw_reg : 25'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= scss_pkg::CP_INIT;
            start_reg <= 32'd0;
            rrc_reg   <= 8'd0;
            chk_reg   <= 8'd0;
            ver_reg   <= 1'b0;
            wp_reg    <= 1'b0;
            pw_reg    <= 25'd0;
        end else begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            rrc_reg   <= rrc_next;
            chk_reg   <= chk_next;
            ver_reg   <= ver_next;
            wp_reg    <= wp_next;
            pw_reg    <= pw_next;
        end
    end

endmodule

/* sv/scss_sample_fsm.sv */
module scss_sample_fsm (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  scss_pkg::cfg_t          cfg,
    input  scss_pkg::item_t         item,
    input  logic                    run,
    input  logic                    restart_set,
    input  logic                    start,
    input  logic                    stop,
    input  logic                    pop,
    output scss_pkg::samp_stat_t    stat
);

    scss_pkg::samp_phase_t phase_reg, phase_next, phase_eff, step_phase;
    logic [31:0] start_reg, start_next, start_eff, step_start;
    logic        on_reg, on_next;
    logic        restart_reg, restart_next;
    scss_pkg::ring_idx_t head_reg, head_next, tail_reg, tail_next, tail_adv;
    scss_pkg::ring_entry_t ring_reg [scss_pkg::RING_DEPTH];
    logic [15:0] limit;
    logic        timed_out;
    logic        store;
    logic        not_empty;
    scss_pkg::cmd_t step_cmd;

    always_comb begin
        phase_eff = restart_reg ? scss_pkg::SP_WAIT_READY : phase_reg;
        start_eff = restart_reg ? item.now : start_reg;
        limit     = (phase_eff == scss_pkg::SP_DELAY) ? cfg.sample_delay
                                                      : cfg.ready_timeout;
        timed_out = scss_pkg::elapsed(item.now, start_eff, limit);

        step_phase = phase_eff;
        step_start = start_eff;
        step_cmd   = scss_pkg::CMD_NONE;
        store      = 1'b0;

        unique case (phase_eff)
            scss_pkg::SP_INIT: begin
            end
            scss_pkg::SP_WAIT_READY: begin
                if (item.sensor_ready || timed_out) begin
                    step_phase = scss_pkg::SP_REQUEST;
                end
            end
            scss_pkg::SP_REQUEST: begin
                step_cmd   = scss_pkg::CMD_READ_ADC;
                step_start = item.now;
                step_phase = scss_pkg::SP_WAIT_DATA;
            end
            scss_pkg::SP_WAIT_DATA: begin
                if (item.sensor_ready) begin
                    // Only good frames flagged out of range are kept.
                    store      = item.rx_ok && item.rx_out_of_range;
                    step_start = item.now;
                    step_phase = scss_pkg::SP_DELAY;
                end else if (timed_out) begin
                    step_start = item.now;
                    step_phase = scss_pkg::SP_DELAY;
                end
            end
            scss_pkg::SP_DELAY: begin
                if (timed_out) begin
                    step_phase = scss_pkg::SP_WAIT_READY;
                end
            end
            default: begin
            end
        endcase

        store     = store && run;
        not_empty = (head_reg != tail_reg);
        tail_adv  = scss_pkg::ring_next(tail_reg);

        phase_next = run ? step_phase : phase_reg;
        start_next = run ? step_start : start_reg;

        head_next = head_reg;
        tail_next = tail_reg;
        if (start) begin
            head_next = '0;
            tail_next = '0;
        end else if (pop && not_empty) begin
            head_next = scss_pkg::ring_next(head_reg);
        end else if (store) begin
            tail_next = tail_adv;
            // A full ring drops its oldest sample.
            if (tail_adv == head_reg) begin
                head_next = scss_pkg::ring_next(head_reg);
            end
        end

        on_next = start ? 1'b1 : (stop ? 1'b0 : on_reg);
        if (start || restart_set) begin
            restart_next = 1'b1;
        end else if (stop || run) begin
            restart_next = 1'b0;
        end else begin
            restart_next = restart_reg;
        end

        stat.sampling_on = on_reg;
        stat.cmd         = run ? step_cmd : scss_pkg::CMD_NONE;
        stat.pop_valid   = pop && not_empty;
        stat.pop_value   = stat.pop_valid ? ring_reg[head_reg].value : 14'd0;
        stat.pop_time    = stat.pop_valid ? ring_reg[head_reg].stamp : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            ring_reg[tail_reg] <= '{value: item.rx_adc_value, stamp: item.now};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= scss_pkg::SP_INIT;
            start_reg   <= 32'd0;
            on_reg      <= 1'b0;
            restart_reg <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
        end else begin
            phase_reg   <= phase_next;
            start_reg   <= start_next;
            on_reg      <= on_next;
            restart_reg <= restart_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
        end
    end

endmodule

/* sv/scss_out_queue.sv */
module scss_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  scss_pkg::result_t   din,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output scss_pkg::result_t   head
);

    logic [1:0]        cnt_reg, cnt_next;
    scss_pkg::result_t slot0_reg, slot1_reg;
    logic              pop;

    always_comb begin
        pop      = (cnt_reg != 2'd0) && m_ready;
        room     = (cnt_reg != 2'd2) || m_ready;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        m_valid  = (cnt_reg != 2'd0);
        head     = slot0_reg;
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            slot0_reg <= (cnt_reg == 2'd2) ? slot1_reg : din;
            slot1_reg <= din;
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                slot0_reg <= din;
            end else begin
                slot1_reg <= din;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* sv/sensor_config_and_sample_sequencer.sv */
// Channel   Direction  Payload
// s_*       in         command request: tuser = func, tdata = step inputs
// m_*       out        one result per request
// cfg_*     in         register write port, no read-back
//
// One request is accepted every cycle while the result queue has room.
// The state update is one pass of logic between the input register and the
// two-entry result queue, so the rate is set by nothing but the handshakes.
// Reset is synchronous on aresetn; the ring keeps no reset.
// With the queue full and m_tready low, the input register holds its request
// and s_tready falls; at most three requests are buffered inside.
`include "assert_macros.svh"

module sensor_config_and_sample_sequencer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now[31:0], sensor_ready[32], rx_ok[33], rx_conf_word[58:34],
    // rx_adc_value[72:59], rx_out_of_range[73], new_conf_word[98:74], zeros above
    input  logic [103:0] s_tdata,
    // func[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // link_cmd[1:0], write_word[26:2], sample_valid[27], sample_value[41:28],
    // sample_time[73:42], conf_verified[74], zeros above
    output logic [79:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);

    scss_pkg::cfg_t        cfg_reg, cfg_next;
    scss_pkg::item_t       in_item_reg, s_item;
    logic                  in_valid_reg, in_valid_next;
    scss_pkg::top_mode_t   mode_reg, mode_next;
    scss_pkg::conf_stat_t  conf_st;
    scss_pkg::samp_stat_t  samp_st;
    scss_pkg::result_t     res, q_head;
    logic                  q_room, advance, s_accept;
    logic                  is_step, take_write, is_start, is_stop, is_pop;
    logic                  run_conf, run_samp, restart_set;
    logic                  both_cmds, in_hold;

    always_comb begin
        s_item.func            = scss_pkg::func_t'(s_tuser);
        s_item.now             = s_tdata[31:0];
        s_item.sensor_ready    = s_tdata[32];
        s_item.rx_ok           = s_tdata[33];
        s_item.rx_conf_word    = s_tdata[58:34];
        s_item.rx_adc_value    = s_tdata[72:59];
        s_item.rx_out_of_range = s_tdata[73];
        s_item.new_conf_word   = s_tdata[98:74];

        advance       = in_valid_reg && q_room;
        s_tready      = !in_valid_reg || advance;
        s_accept      = s_tvalid && s_tready;
        in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        in_hold       = in_valid_reg && !advance;
    end

    always_comb begin
        is_step    = 1'b0;
        take_write = 1'b0;
        is_start   = 1'b0;
        is_stop    = 1'b0;
        is_pop     = 1'b0;
        unique case (in_item_reg.func)
            scss_pkg::FUNC_STEP:       is_step    = advance;
            scss_pkg::FUNC_WRITE_CONF: take_write = advance;
            scss_pkg::FUNC_START:      is_start   = advance;
            scss_pkg::FUNC_STOP:       is_stop    = advance;
            scss_pkg::FUNC_POP:        is_pop     = advance;
            default: begin
            end
        endcase

        mode_next = mode_reg;
        if (is_step) begin
            if (conf_st.write_pending) begin
                mode_next = scss_pkg::TM_CONF;
            end else if (conf_st.ready) begin
                mode_next = samp_st.sampling_on ? scss_pkg::TM_SAMPLE : scss_pkg::TM_IDLE;
            end
        end
        run_conf    = is_step && (mode_next == scss_pkg::TM_CONF);
        run_samp    = is_step && (mode_next == scss_pkg::TM_SAMPLE);
        restart_set = is_step && conf_st.write_pending && samp_st.sampling_on;

        res.link_cmd      = (conf_st.cmd != scss_pkg::CMD_NONE) ? conf_st.cmd : samp_st.cmd;
        res.write_word    = conf_st.write_word;
        res.sample_valid  = samp_st.pop_valid;
        res.sample_value  = samp_st.pop_value;
        res.sample_time   = samp_st.pop_time;
        res.conf_verified = conf_st.verified;

        both_cmds = (conf_st.cmd != scss_pkg::CMD_NONE) && (samp_st.cmd != scss_pkg::CMD_NONE);
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                scss_pkg::CFG_READY_TIMEOUT: cfg_next.ready_timeout     = cfg_wdata;
                scss_pkg::CFG_APPLY_DELAY:   cfg_next.apply_delay       = cfg_wdata;
                scss_pkg::CFG_SAMPLE_DELAY:  cfg_next.sample_delay      = cfg_wdata;
                scss_pkg::CFG_READ_RETRY:    cfg_next.read_retry_limit  = cfg_wdata[7:0];
                scss_pkg::CFG_CHECK_RETRY:   cfg_next.check_retry_limit = cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg                  <= 1'b0;
            mode_reg                      <= scss_pkg::TM_IDLE;
            cfg_reg.ready_timeout         <= scss_pkg::RESET_READY_TIMEOUT;
            cfg_reg.apply_delay           <= scss_pkg::RESET_APPLY_DELAY;
            cfg_reg.sample_delay          <= scss_pkg::RESET_SAMPLE_DELAY;
            cfg_reg.read_retry_limit      <= scss_pkg::RESET_READ_RETRY;
            cfg_reg.check_retry_limit     <= scss_pkg::RESET_CHECK_RETRY;
        end else begin
            in_valid_reg <= in_valid_next;
            mode_reg     <= mode_next;
            cfg_reg      <= cfg_next;
        end
    end

    scss_conf_fsm u_conf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item       (in_item_reg),
        .take_write (take_write),
        .run        (run_conf),
        .stat       (conf_st)
    );

    scss_sample_fsm u_sample (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .item        (in_item_reg),
        .run         (run_samp),
        .restart_set (restart_set),
        .start       (is_start),
        .stop        (is_stop),
        .pop         (is_pop),
        .stat        (samp_st)
    );

    scss_out_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (advance),
        .din     (res),
        .room    (q_room),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .head    (q_head)
    );

    assign m_tdata = {5'd0, q_head.conf_verified, q_head.sample_time, q_head.sample_value,
                      q_head.sample_valid, q_head.write_word, q_head.link_cmd};

    `ASSERT_ALWAYS(a_one_link_cmd, !both_cmds, "both sequencers issued a link command")
    `ASSERT_NEXT(a_verified_sticky, conf_st.verified, conf_st.verified, "verified flag dropped")
    `ASSERT_NEXT(a_result_follows, advance, m_tvalid, "request advanced but no result queued")
    `ASSERT_NEXT(a_in_hold, in_hold, in_valid_reg && $stable(in_item_reg), "held request changed")

endmodule

/* tb/sv/sensor_config_and_sample_sequencer_tb.sv */
module sensor_config_and_sample_sequencer_tb;
    import scss_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_ITEMS = 200;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BLOCKED} sink_mode_t;

    typedef struct {
        item_t   it;
        logic    typed;
        result_t want;
    } row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic         cfg_wr_en;
    logic [2:0]   cfg_addr;
    logic [15:0]  cfg_wdata;

    sensor_config_and_sample_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted state of the sequencer.
    cfg_t        regs;
    top_mode_t   mode;
    conf_phase_t cph;
    samp_phase_t sph;
    logic [31:0] conf_t0;
    logic [31:0] samp_t0;
    logic [7:0]  read_tries;
    logic [7:0]  check_tries;
    logic [24:0] word_to_write;
    logic        write_req;
    logic        verified;
    logic        sampling;
    logic        samp_restart;
    ring_entry_t ring [RING_DEPTH];
    ring_idx_t   head;
    ring_idx_t   tail;

    row_t    plan_q[$];
    row_t    issued[$];
    result_t expected_results[$];
    int      fail_count = 0;
    int      quiet = 0;
    int      burst_left = 0;
    logic [31:0] tick = 32'd0;
    logic [24:0] last_word = 25'd0;

    sink_mode_t  sink_mode = SINK_OPEN;
    logic [31:0] sink_cycle = 32'd0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // A time gap taken backward counts one tick more than the same gap forward.
    function automatic logic ticks_exceeded(logic [31:0] now, logic [31:0] start,
                                            logic [15:0] limit);
        logic [31:0] gap;
        gap = (now >= start) ? now - start : start - now + 32'd1;
        return gap > {16'd0, limit};
    endfunction

    function automatic ring_idx_t ring_after(ring_idx_t i);
        return (i == ring_idx_t'(RING_DEPTH - 1)) ? ring_idx_t'(0) : ring_idx_t'(i + 1'b1);
    endfunction

    function automatic cmd_t conf_advance(item_t it);
        cmd_t c;
        c = CMD_NONE;
        if (write_req) begin
            cph = CP_WAIT_WRITE;
            write_req = 1'b0;
            conf_t0 = it.now;
        end
        case (cph)
            CP_WAIT_WRITE: begin
                if (it.sensor_ready || ticks_exceeded(it.now, conf_t0, regs.ready_timeout))
                    cph = CP_WRITE;
            end
            CP_WRITE: begin
                c = CMD_WRITE;
                check_tries = 8'd0;
                conf_t0 = it.now;
                cph = CP_WAIT_APPLY;
            end
            CP_WAIT_APPLY: begin
                if (ticks_exceeded(it.now, conf_t0, regs.apply_delay)) begin
                    conf_t0 = it.now;
                    read_tries = 8'd0;
                    cph = CP_WAIT_READ;
                end
            end
            CP_WAIT_READ: begin
                if (it.sensor_ready || ticks_exceeded(it.now, conf_t0, regs.ready_timeout))
                    cph = CP_READ;
            end
            CP_READ: begin
                c = CMD_READ_FULL;
                conf_t0 = it.now;
                cph = CP_WAIT_CHECK;
            end
            CP_WAIT_CHECK: begin
                if (it.sensor_ready) begin
                    cph = CP_CHECK;
                end else if (ticks_exceeded(it.now, conf_t0, regs.ready_timeout)) begin
                    cph = (read_tries < regs.read_retry_limit) ? CP_READ : CP_WRITE;
                    if (read_tries != 8'hFF) read_tries = read_tries + 8'd1;
                end
            end
            CP_CHECK: begin
                // The readback is compared even when the frame status is bad.
                if (it.rx_conf_word == word_to_write) begin
                    verified = 1'b1;
                    cph = CP_READY;
                end else begin
                    cph = (check_tries < regs.check_retry_limit) ? CP_READ : CP_WRITE;
                    if (check_tries != 8'hFF) check_tries = check_tries + 8'd1;
                end
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic cmd_t sample_advance(item_t it);
        cmd_t c;
        c = CMD_NONE;
        if (samp_restart) begin
            sph = SP_WAIT_READY;
            samp_restart = 1'b0;
            samp_t0 = it.now;
        end
        case (sph)
            SP_WAIT_READY: begin
                if (it.sensor_ready || ticks_exceeded(it.now, samp_t0, regs.ready_timeout))
                    sph = SP_REQUEST;
            end
            SP_REQUEST: begin
                c = CMD_READ_ADC;
                samp_t0 = it.now;
                sph = SP_WAIT_DATA;
            end
            SP_WAIT_DATA: begin
                if (it.sensor_ready) begin
                    if (it.rx_ok && it.rx_out_of_range) begin
                        ring[tail].value = it.rx_adc_value;
                        ring[tail].stamp = it.now;
                        tail = ring_after(tail);
                        // A full ring drops its oldest sample.
                        if (head == tail) head = ring_after(head);
                    end
                    samp_t0 = it.now;
                    sph = SP_DELAY;
                end else if (ticks_exceeded(it.now, samp_t0, regs.ready_timeout)) begin
                    samp_t0 = it.now;
                    sph = SP_DELAY;
                end
            end
            SP_DELAY: begin
                if (ticks_exceeded(it.now, samp_t0, regs.sample_delay))
                    sph = SP_WAIT_READY;
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic result_t sequencer_result(item_t it);
        result_t r;
        r = '0;
        case (it.func)
            FUNC_STEP: begin
                if (write_req) begin
                    mode = TM_CONF;
                    if (sampling) samp_restart = 1'b1;
                end else if (cph == CP_READY) begin
                    mode = sampling ? TM_SAMPLE : TM_IDLE;
                end
                if (mode == TM_CONF) r.link_cmd = conf_advance(it);
                else if (mode == TM_SAMPLE) r.link_cmd = sample_advance(it);
                if (r.link_cmd == CMD_WRITE) r.write_word = word_to_write;
            end
            FUNC_WRITE_CONF: begin
                word_to_write = it.new_conf_word;
                write_req = 1'b1;
            end
            FUNC_START: begin
                head = '0;
                tail = '0;
                sampling = 1'b1;
                samp_restart = 1'b1;
            end
            FUNC_STOP: begin
                sampling = 1'b0;
                samp_restart = 1'b0;
            end
            FUNC_POP: begin
                if (head != tail) begin
                    r.sample_valid = 1'b1;
                    r.sample_value = ring[head].value;
                    r.sample_time = ring[head].stamp;
                    head = ring_after(head);
                end
            end
            default: ;
        endcase
        r.conf_verified = verified;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        row_t    req;
        result_t got;
        result_t want;
        if (!aresetn) begin
            regs = '{RESET_READY_TIMEOUT, RESET_APPLY_DELAY, RESET_SAMPLE_DELAY,
                     RESET_READ_RETRY, RESET_CHECK_RETRY};
            mode = TM_IDLE;
            cph = CP_INIT;
            sph = SP_INIT;
            conf_t0 = '0;
            samp_t0 = '0;
            read_tries = '0;
            check_tries = '0;
            word_to_write = '0;
            write_req = 1'b0;
            verified = 1'b0;
            sampling = 1'b0;
            samp_restart = 1'b0;
            foreach (ring[i]) ring[i] = '0;
            head = '0;
            tail = '0;
            quiet <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.link_cmd      = cmd_t'(m_tdata[1:0]);
                got.write_word    = m_tdata[26:2];
                got.sample_valid  = m_tdata[27];
                got.sample_value  = m_tdata[41:28];
                got.sample_time   = m_tdata[73:42];
                got.conf_verified = m_tdata[74];
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("link_cmd", want.link_cmd, got.link_cmd);
                    check_field("write_word", want.write_word, got.write_word);
                    check_field("sample_valid", want.sample_valid, got.sample_valid);
                    check_field("sample_value", want.sample_value, got.sample_value);
                    check_field("sample_time", want.sample_time, got.sample_time);
                    check_field("conf_verified", want.conf_verified, got.conf_verified);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_READY_TIMEOUT: regs.ready_timeout = cfg_wdata;
                    CFG_APPLY_DELAY:   regs.apply_delay = cfg_wdata;
                    CFG_SAMPLE_DELAY:  regs.sample_delay = cfg_wdata;
                    CFG_READ_RETRY:    regs.read_retry_limit = cfg_wdata[7:0];
                    CFG_CHECK_RETRY:   regs.check_retry_limit = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                req = issued.pop_front();
                want = sequencer_result(req.it);
                expected_results.push_back(req.typed ? req.want : want);
            end
            quiet <= ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                     ? 0 : quiet + 1;
        end
    end

    // The result side switches at random among its own stall patterns.
    always @(posedge aclk) begin
        sink_cycle <= sink_cycle + 32'd1;
        if (sink_cycle[5:0] == 6'd0) sink_mode <= sink_mode_t'($urandom_range(0, 3));
        case (sink_mode)
            SINK_OPEN:   m_tready <= 1'b1;
            SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: m_tready <= (sink_cycle[1:0] == 2'd0);
            default:     m_tready <= (sink_cycle[4:0] > 5'd24);
        endcase
    end

    initial begin
        wait (quiet >= QUIET_LIMIT);
        $display("sensor_config_and_sample_sequencer verification failed");
        $finish;
    end

    function automatic item_t make_request(func_t f, logic [31:0] t, logic rdy, logic ok,
                                           logic [24:0] cw, logic [13:0] adc, logic oor,
                                           logic [24:0] nw);
        item_t it;
        it.func = f;
        it.now = t;
        it.sensor_ready = rdy;
        it.rx_ok = ok;
        it.rx_conf_word = cw;
        it.rx_adc_value = adc;
        it.rx_out_of_range = oor;
        it.new_conf_word = nw;
        return it;
    endfunction

    function automatic result_t outcome(cmd_t c, logic [24:0] w, logic v, logic [13:0] sv,
                                        logic [31:0] st, logic cv);
        result_t r;
        r.link_cmd = c;
        r.write_word = w;
        r.sample_valid = v;
        r.sample_value = sv;
        r.sample_time = st;
        r.conf_verified = cv;
        return r;
    endfunction

    task automatic plan_row(item_t it, logic typed, result_t want);
        row_t r;
        r.it = it;
        r.typed = typed;
        r.want = want;
        plan_q.push_back(r);
    endtask

    function automatic item_t random_item(func_t f);
        item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) tick = tick + $urandom_range(0, 3);
        else if (pick < 88) tick = tick + $urandom_range(4, 120);
        else if (pick < 94) tick = $urandom;
        else tick = tick - $urandom_range(1, 12);
        it.func = f;
        it.now = tick;
        it.sensor_ready = ($urandom_range(0, 99) < 45);
        it.rx_ok = ($urandom_range(0, 99) < 80);
        it.rx_conf_word = ($urandom_range(0, 99) < 65) ? last_word : 25'($urandom);
        it.rx_adc_value = 14'($urandom);
        it.rx_out_of_range = ($urandom_range(0, 99) < 60);
        it.new_conf_word = 25'($urandom);
        if (f == FUNC_WRITE_CONF) last_word = it.new_conf_word;
        return it;
    endfunction

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    task automatic send_req(item_t it, logic typed, result_t want);
        row_t r;
        r.it = it;
        r.typed = typed;
        r.want = want;
        pace_sender();
        issued.push_back(r);
        s_tvalid <= 1'b1;
        s_tuser <= it.func;
        s_tdata <= {5'd0, it.new_conf_word, it.rx_out_of_range, it.rx_adc_value,
                    it.rx_conf_word, it.rx_ok, it.sensor_ready, it.now};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Registers change only once every request has produced its result.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (issued.size() != 0 || expected_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic load_regs(cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_READY_TIMEOUT;
        cfg_wdata <= c.ready_timeout;
        @(posedge aclk);
        cfg_addr <= CFG_APPLY_DELAY;
        cfg_wdata <= c.apply_delay;
        @(posedge aclk);
        cfg_addr <= CFG_SAMPLE_DELAY;
        cfg_wdata <= c.sample_delay;
        @(posedge aclk);
        // The upper byte of the 8-bit registers must be ignored.
        cfg_addr <= CFG_READ_RETRY;
        cfg_wdata <= {8'($urandom), c.read_retry_limit};
        @(posedge aclk);
        cfg_addr <= CFG_CHECK_RETRY;
        cfg_wdata <= {8'($urandom), c.check_retry_limit};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        cfg_t settings [8];
        func_t f;
        int pick;

        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed walk with the reset register values: idle commands, sampling
        // before configuration, a full write and readback with a timed-out read
        // and a mismatch, then one stored sample popped back.
        plan_row(make_request(FUNC_POP, 0, 0, 0, 0, 0, 0, 0), 1,
                 outcome(CMD_NONE, 0, 0, 0, 0, 0));
        plan_row(make_request(FUNC_STEP, 0, 1, 1, 0, 0, 0, 0), 1,
                 outcome(CMD_NONE, 0, 0, 0, 0, 0));
        plan_row(make_request(func_t'(3'd5), 0, 1, 1, '1, '1, 1, '1), 1,
                 outcome(CMD_NONE, 0, 0, 0, 0, 0));
        plan_row(make_request(FUNC_START, 0, 0, 0, 0, 0, 0, 0), 1,
                 outcome(CMD_NONE, 0, 0, 0, 0, 0));
        plan_row(make_request(FUNC_STEP, 10, 1, 1, 0, 14'h1234, 1, 0), 1,
                 outcome(CMD_NONE, 0, 0, 0, 0, 0));
        plan_row(make_request(FUNC_WRITE_CONF, 0, 0, 0, 0, 0, 0, 25'h1FFFFFF), 1,
                 outcome(CMD_NONE, 0, 0, 0, 0, 0));
        plan_row(make_request(FUNC_STEP, 100, 0, 0, 0, 0, 0, 0), 0, '0);
        plan_row(make_request(FUNC_STEP, 107, 0, 0, 0, 0, 0, 0), 0, '0);
        plan_row(make_request(FUNC_STEP, 107, 0, 0, 0, 0, 0, 0), 1,
                 outcome(CMD_WRITE, 25'h1FFFFFF, 0, 0, 0, 0));
        plan_row(make_request(FUNC_STEP, 111, 0, 0, 0, 0, 0, 0), 0, '0);
        plan_row(make_request(FUNC_STEP, 111, 1, 0, 0, 0, 0, 0), 0, '0);
        plan_row(make_request(FUNC_STEP, 111, 0, 0, 0, 0, 0, 0), 1,
                 outcome(CMD_READ_FULL, 0, 0, 0, 0, 0));
        // Time stepping backward: six ticks back already counts as a timeout.
        plan_row(make_request(FUNC_STEP, 105, 0, 0, 0, 0, 0, 0), 0, '0);
        plan_row(make_request(FUNC_STEP, 105, 0, 0, 0, 0, 0, 0), 1,
                 outcome(CMD_READ_FULL, 0, 0, 0, 0, 0));
        plan_row(make_request(FUNC_STEP, 105, 1, 1, 0, 0, 0, 0), 0, '0);
        plan_row(make_request(FUNC_STEP, 105, 0, 1, 0, 0, 0, 0), 0, '0);
        plan_row(make_request(FUNC_STEP, 105, 0, 1, 0, 0, 0, 0), 1,
                 outcome(CMD_READ_FULL, 0, 0, 0, 0, 0));
        plan_row(make_request(FUNC_STEP, 105, 1, 0, 0, 0, 0, 0), 0, '0);
        plan_row(make_request(FUNC_STEP, 105, 0, 0, 25'h1FFFFFF, 0, 0, 0), 0, '0);
        plan_row(make_request(FUNC_STEP, 200, 1, 0, 0, 0, 0, 0), 0, '0);
        plan_row(make_request(FUNC_STEP, 200, 0, 0, 0, 0, 0, 0), 1,
                 outcome(CMD_READ_ADC, 0, 0, 0, 0, 1));
        plan_row(make_request(FUNC_STEP, 32'hFFFFFFFF, 1, 1, 0, 14'h3FFF, 1, 0), 0, '0);
        plan_row(make_request(FUNC_POP, 0, 0, 0, 0, 0, 0, 0), 1,
                 outcome(CMD_NONE, 0, 1, 14'h3FFF, 32'hFFFFFFFF, 1));
        plan_row(make_request(FUNC_STOP, 0, 0, 0, 0, 0, 0, 0), 1,
                 outcome(CMD_NONE, 0, 0, 0, 0, 1));
        plan_row(make_request(func_t'(3'd7), 0, 1, 1, '1, '1, 1, '1), 1,
                 outcome(CMD_NONE, 0, 0, 0, 0, 1));
        foreach (plan_q[i]) send_req(plan_q[i].it, plan_q[i].typed, plan_q[i].want);

        settings[0] = '{16'd0, 16'd0, 16'd0, 8'd0, 8'd0};
        settings[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF};
        settings[2] = '{RESET_READY_TIMEOUT, RESET_APPLY_DELAY, RESET_SAMPLE_DELAY,
                        RESET_READ_RETRY, RESET_CHECK_RETRY};
        for (int p = 3; p < 8; p++) begin
            settings[p] = '{16'($urandom_range(0, 12)), 16'($urandom_range(0, 8)),
                            16'($urandom_range(0, 40)), 8'($urandom_range(0, 4)),
                            8'($urandom_range(0, 4))};
        end

        foreach (settings[p]) begin
            drain();
            load_regs(settings[p]);
            // Each phase opens with a well-formed configure-then-sample request pair.
            send_req(random_item(FUNC_WRITE_CONF), 0, '0);
            send_req(random_item(FUNC_START), 0, '0);
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 78) f = FUNC_STEP;
                else if (pick < 82) f = FUNC_WRITE_CONF;
                else if (pick < 86) f = FUNC_START;
                else if (pick < 88) f = FUNC_STOP;
                else if (pick < 98) f = FUNC_POP;
                else f = func_t'(3'($urandom_range(5, 7)));
                send_req(random_item(f), 0, '0);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("sensor_config_and_sample_sequencer verification clean");
        end else begin
            $display("sensor_config_and_sample_sequencer verification failed");
        end
        $finish;
    end

endmodule
